### sv/assert_macros.svh
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, masked while reset is high
`define MID_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies another one on the following edge
`define MID_ASSERT_NEXT(name, clk, rst, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

### sv/mid_pkg.sv
package mid_pkg;

  // Opcode patterns and ModRM field values
  localparam logic [3:0] OP_IMM_REG   = 4'b1011;
  localparam logic [5:0] OP_RM_REG    = 6'b100010;
  localparam logic [1:0] MOD_REGISTER = 2'b11;
  localparam logic [1:0] MOD_DISP8    = 2'b01;
  localparam logic [1:0] MOD_DISP16   = 2'b10;
  localparam logic [1:0] MOD_NODISP   = 2'b00;
  localparam logic [2:0] RM_DIRECT    = 3'b110;

  // Default depth of the queue between parser and formatter
  localparam int QUEUE_DEPTH_DEF = 4;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_TRUNC   = 2'd2
  } status_t;

  // Instruction forms
  typedef enum logic [1:0] {
    FORM_IMM_REG = 2'd0,
    FORM_REG_REG = 2'd1,
    FORM_MEM_REG = 2'd2,
    FORM_REG_MEM = 2'd3
  } form_t;

  // Which encoding completed
  typedef enum logic [2:0] {
    K_IMM8,
    K_IMM16,
    K_REGREG,
    K_MEM_NODISP,
    K_MEM_D8,
    K_MEM_D16
  } kind_t;

  // Raw instruction bytes handed from parser to formatter
  typedef struct packed {
    status_t     status;
    kind_t       kind;
    logic [7:0]  opcode;
    logic [7:0]  modrm;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [15:0] position;
  } rec_t;

endpackage

### sv/mid_front.sv
module mid_front import mid_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] code_byte,
  input  logic       stream_end,
  output logic       push,
  output rec_t       rec
);

  typedef enum logic [2:0] {
    PH_OPCODE,
    PH_IMM_LO,
    PH_IMM_HI,
    PH_MODRM,
    PH_DISP_LO,
    PH_DISP_HI
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  opcode, opcode_next;
  logic [7:0]  modrm, modrm_next;
  logic [7:0]  low_byte, low_byte_next;
  logic [15:0] byte_count, byte_count_next;
  logic [15:0] start_offset, start_offset_next;
  logic        halted, halted_next;
  status_t     status;
  kind_t       kind;

  // Parse one byte and decide whether an instruction completes
  always_comb begin
    phase_next        = phase;
    opcode_next       = opcode;
    modrm_next        = modrm;
    low_byte_next     = low_byte;
    byte_count_next   = byte_count;
    start_offset_next = start_offset;
    halted_next       = halted;
    push              = 1'b0;
    status            = ST_OK;
    kind              = K_IMM8;
    if (accept) begin
      if (halted) begin
        if (stream_end) begin
          halted_next     = 1'b0;
          phase_next      = PH_OPCODE;
          byte_count_next = '0;
        end
      end else begin
        byte_count_next = byte_count + 16'd1;
        case (phase)
          PH_OPCODE: begin
            start_offset_next = byte_count;
            opcode_next       = code_byte;
            if (code_byte[7:4] == OP_IMM_REG) begin
              phase_next = PH_IMM_LO;
            end else if (code_byte[7:2] == OP_RM_REG) begin
              phase_next = PH_MODRM;
            end else begin
              push        = 1'b1;
              status      = ST_UNKNOWN;
              halted_next = !stream_end;
            end
          end
          PH_IMM_LO: begin
            low_byte_next = code_byte;
            if (opcode[3]) begin
              phase_next = PH_IMM_HI;
            end else begin
              push       = 1'b1;
              kind       = K_IMM8;
              phase_next = PH_OPCODE;
            end
          end
          PH_IMM_HI: begin
            push       = 1'b1;
            kind       = K_IMM16;
            phase_next = PH_OPCODE;
          end
          PH_MODRM: begin
            modrm_next = code_byte;
            if (code_byte[7:6] == MOD_REGISTER) begin
              push       = 1'b1;
              kind       = K_REGREG;
              phase_next = PH_OPCODE;
            end else if (code_byte[7:6] == MOD_DISP8 || code_byte[7:6] == MOD_DISP16 ||
                         code_byte[2:0] == RM_DIRECT) begin
              phase_next = PH_DISP_LO;
            end else begin
              push       = 1'b1;
              kind       = K_MEM_NODISP;
              phase_next = PH_OPCODE;
            end
          end
          PH_DISP_LO: begin
            low_byte_next = code_byte;
            if (modrm[7:6] == MOD_DISP8) begin
              push       = 1'b1;
              kind       = K_MEM_D8;
              phase_next = PH_OPCODE;
            end else begin
              phase_next = PH_DISP_HI;
            end
          end
          PH_DISP_HI: begin
            push       = 1'b1;
            kind       = K_MEM_D16;
            phase_next = PH_OPCODE;
          end
          default: begin
            phase_next = PH_OPCODE;
          end
        endcase
        // Close the stream; flag an instruction cut short
        if (stream_end) begin
          if (!push && phase_next != PH_OPCODE) begin
            push   = 1'b1;
            status = ST_TRUNC;
          end
          phase_next      = PH_OPCODE;
          byte_count_next = '0;
          halted_next     = 1'b0;
        end
      end
    end
  end

  // Pack the raw bytes of the completed instruction
  assign rec = '{status:   status,
                 kind:     kind,
                 opcode:   opcode_next,
                 modrm:    modrm_next,
                 lo:       low_byte_next,
                 hi:       code_byte,
                 position: start_offset_next};

  // Hold parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_OPCODE;
      byte_count   <= '0;
      start_offset <= '0;
      halted       <= 1'b0;
    end else begin
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      start_offset <= start_offset_next;
      halted       <= halted_next;
    end
  end

  // Payload bytes need no reset
  always_ff @(posedge clk) begin
    opcode   <= opcode_next;
    modrm    <= modrm_next;
    low_byte <= low_byte_next;
  end

endmodule

### sv/mid_queue.sv
module mid_queue import mid_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  rec_t                       push_rec,
  input  logic                       pop,
  output rec_t                       head,
  output logic                       full,
  output logic                       nonempty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  rec_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  assign head     = mem[rd_ptr];
  assign full     = (count == CNT_W'(DEPTH));
  assign nonempty = (count != '0);

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

endmodule

### sv/mid_back.sv
module mid_back import mid_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        avail,
  input  rec_t        head,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  // form, wide, dest_reg, src_reg, ea_mode, direct_addr, displacement,
  // immediate, position, zero fill
  output logic [63:0] m_tdata,
  // status
  output logic [1:0]  m_tuser
);

  form_t              form;
  logic               wide;
  logic [2:0]         dest_reg;
  logic [2:0]         src_reg;
  logic [2:0]         ea_mode;
  logic               direct_addr;
  logic signed [15:0] displacement;
  logic [15:0]        immediate;
  logic [2:0]         reg_fld;
  logic [2:0]         rm_fld;

  assign reg_fld = head.modrm[5:3];
  assign rm_fld  = head.modrm[2:0];

  // Turn raw bytes into result fields
  always_comb begin
    form         = FORM_IMM_REG;
    wide         = 1'b0;
    dest_reg     = '0;
    src_reg      = '0;
    ea_mode      = '0;
    direct_addr  = 1'b0;
    displacement = '0;
    immediate    = '0;
    if (head.status == ST_OK) begin
      case (head.kind)
        K_IMM8: begin
          dest_reg  = head.opcode[2:0];
          immediate = {8'h00, head.lo};
        end
        K_IMM16: begin
          wide      = 1'b1;
          dest_reg  = head.opcode[2:0];
          immediate = {head.hi, head.lo};
        end
        K_REGREG: begin
          form = FORM_REG_REG;
          wide = head.opcode[0];
          if (head.opcode[1]) begin
            dest_reg = reg_fld;
            src_reg  = rm_fld;
          end else begin
            dest_reg = rm_fld;
            src_reg  = reg_fld;
          end
        end
        K_MEM_NODISP, K_MEM_D8, K_MEM_D16: begin
          wide    = head.opcode[0];
          ea_mode = rm_fld;
          if (head.opcode[1]) begin
            form     = FORM_MEM_REG;
            dest_reg = reg_fld;
          end else begin
            form    = FORM_REG_MEM;
            src_reg = reg_fld;
          end
          if (head.kind == K_MEM_D8) begin
            displacement = {{8{head.lo[7]}}, head.lo};
          end else if (head.kind == K_MEM_D16) begin
            displacement = {head.hi, head.lo};
            direct_addr  = (head.modrm[7:6] == MOD_NODISP);
          end
        end
        default: begin
          form = FORM_IMM_REG;
        end
      endcase
    end
  end

  // Take the next entry whenever the output register is free
  assign pop = avail && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (pop) begin
      m_tuser <= head.status;
      m_tdata <= {3'b000, head.position, immediate, displacement, direct_addr,
                  ea_mode, src_reg, dest_reg, wide, form};
    end
  end

endmodule

### sv/mov_instruction_byte_decoder.sv
// Path: the instruction's last byte writes a result into the result queue; it
//   moves on into the output register, offered on m_tvalid, when that is free.
// Throughput: one code byte per cycle; a result queue of QUEUE_DEPTH entries
//   absorbs output stalls before s_tready drops.
// Reset: rst (synchronous) returns the parser to expect an opcode at offset 0
//   and empties the queue and the output register.
`include "assert_macros.svh"

module mov_instruction_byte_decoder import mid_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // code_byte
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // form, wide, dest_reg, src_reg, ea_mode, direct_addr, displacement,
  // immediate, position, zero fill
  output logic [63:0] m_tdata,
  // status
  output logic [1:0]  m_tuser
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic             accept;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_nonempty;
  logic [CNT_W-1:0] q_count;
  rec_t             push_rec;
  rec_t             head;
  logic             err_out;

  // Hold off input while in reset or while the queue is full
  assign s_tready = !rst && !q_full;
  assign accept   = s_tvalid && s_tready;

  mid_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .code_byte  (s_tdata),
    .stream_end (s_tlast),
    .push       (q_push),
    .rec        (push_rec)
  );

  mid_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_rec (push_rec),
    .pop      (q_pop),
    .head     (head),
    .full     (q_full),
    .nonempty (q_nonempty),
    .count    (q_count)
  );

  mid_back u_back (
    .clk      (clk),
    .rst      (rst),
    .avail    (q_nonempty),
    .head     (head),
    .pop      (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  assign err_out = m_tvalid && (m_tuser != ST_OK);

  // A decoded instruction is never written into a full queue
  `MID_ASSERT(a_no_push_full, clk, rst, !(q_push && q_full), "push into full queue")

  // A written entry is still queued on the next edge
  `MID_ASSERT_NEXT(a_push_held, clk, rst, q_push, q_count != '0, "queued result lost")

  // Error results carry only the stream position
  `MID_ASSERT(a_err_clean, clk, rst, !err_out || m_tdata[44:0] == '0, "error result has payload")

endmodule

### dv/mov_instruction_byte_decoder_tb.sv
module mov_instruction_byte_decoder_tb;
  import mid_pkg::*;

  localparam int RUN_LIMIT = 1000000;

  // Parser position inside one MOV encoding
  typedef enum logic [2:0] {
    PH_OPCODE,
    PH_IMM_LO,
    PH_IMM_HI,
    PH_MODRM,
    PH_DISP_LO,
    PH_DISP_HI
  } decode_phase_t;

  // One decoded instruction as it leaves the block
  typedef struct {
    status_t     status;
    form_t       form;
    logic        wide;
    logic [2:0]  dest_reg;
    logic [2:0]  src_reg;
    logic [2:0]  ea_mode;
    logic        direct_addr;
    logic [15:0] displacement;
    logic [15:0] immediate;
    logic [15:0] position;
  } mov_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [1:0]  m_tuser;

  // Decoder state mirrored on the bench side
  decode_phase_t phase_q = PH_OPCODE;
  logic [7:0]    opcode_q = 8'h00;
  logic [7:0]    modrm_q = 8'h00;
  logic [7:0]    low_q = 8'h00;
  logic [15:0]   byte_pos = 16'h0000;
  logic [15:0]   start_pos = 16'h0000;
  logic          halted_q = 1'b0;

  mov_result_t pending_results[$];
  logic [7:0]  instr_bytes[$];

  int  errors = 0;
  int  live_bytes = 0;
  int  results_seen = 0;
  int  unknown_seen = 0;
  int  trunc_seen = 0;
  bit  idle_en = 1'b1;
  int  stall_left = 0;

  mov_instruction_byte_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #1 clk = ~clk;

  // Result with every field cleared except the instruction offset
  function automatic mov_result_t blank_result();
    mov_result_t r;
    r.status       = ST_OK;
    r.form         = FORM_IMM_REG;
    r.wide         = 1'b0;
    r.dest_reg     = 3'd0;
    r.src_reg      = 3'd0;
    r.ea_mode      = 3'd0;
    r.direct_addr  = 1'b0;
    r.displacement = 16'h0000;
    r.immediate    = 16'h0000;
    r.position     = start_pos;
    return r;
  endfunction

  // Memory-operand MOV from the held opcode and ModRM bytes
  function automatic mov_result_t mem_result(input logic [15:0] disp, input logic direct);
    mov_result_t r;
    r = blank_result();
    r.wide         = opcode_q[0];
    r.ea_mode      = modrm_q[2:0];
    r.direct_addr  = direct;
    r.displacement = disp;
    if (opcode_q[1]) begin
      r.form     = FORM_MEM_REG;
      r.dest_reg = modrm_q[5:3];
    end else begin
      r.form    = FORM_REG_MEM;
      r.src_reg = modrm_q[5:3];
    end
    return r;
  endfunction

  // Advance the decoder by one accepted code byte, queue any finished result
  function automatic void decode_byte(input logic [7:0] b, input logic last);
    mov_result_t r;
    bit          got;
    got = 1'b0;
    r = blank_result();
    if (halted_q) begin
      if (last) begin
        halted_q = 1'b0;
        phase_q  = PH_OPCODE;
        byte_pos = 16'h0000;
      end
      return;
    end
    live_bytes++;
    case (phase_q)
      PH_OPCODE: begin
        start_pos = byte_pos;
        opcode_q  = b;
        if (b[7:4] == OP_IMM_REG) begin
          phase_q = PH_IMM_LO;
        end else if (b[7:2] == OP_RM_REG) begin
          phase_q = PH_MODRM;
        end else begin
          r = blank_result();
          r.status = ST_UNKNOWN;
          got = 1'b1;
          if (!last) halted_q = 1'b1;
        end
      end
      PH_IMM_LO: begin
        low_q = b;
        if (opcode_q[3]) begin
          phase_q = PH_IMM_HI;
        end else begin
          r.dest_reg  = opcode_q[2:0];
          r.immediate = {8'h00, b};
          got = 1'b1;
          phase_q = PH_OPCODE;
        end
      end
      PH_IMM_HI: begin
        r.wide      = 1'b1;
        r.dest_reg  = opcode_q[2:0];
        r.immediate = {b, low_q};
        got = 1'b1;
        phase_q = PH_OPCODE;
      end
      PH_MODRM: begin
        modrm_q = b;
        if (b[7:6] == MOD_REGISTER) begin
          r.form = FORM_REG_REG;
          r.wide = opcode_q[0];
          if (opcode_q[1]) begin
            r.dest_reg = b[5:3];
            r.src_reg  = b[2:0];
          end else begin
            r.dest_reg = b[2:0];
            r.src_reg  = b[5:3];
          end
          got = 1'b1;
          phase_q = PH_OPCODE;
        end else if (b[7:6] == MOD_DISP8 || b[7:6] == MOD_DISP16 || b[2:0] == RM_DIRECT) begin
          phase_q = PH_DISP_LO;
        end else begin
          r = mem_result(16'h0000, 1'b0);
          got = 1'b1;
          phase_q = PH_OPCODE;
        end
      end
      PH_DISP_LO: begin
        low_q = b;
        if (modrm_q[7:6] == MOD_DISP8) begin
          r = mem_result({{8{b[7]}}, b}, 1'b0);
          got = 1'b1;
          phase_q = PH_OPCODE;
        end else begin
          phase_q = PH_DISP_HI;
        end
      end
      default: begin
        r = mem_result({b, low_q}, modrm_q[7:6] == MOD_NODISP);
        got = 1'b1;
        phase_q = PH_OPCODE;
      end
    endcase
    byte_pos = byte_pos + 16'd1;
    // Stream end: flag a cut-off instruction and restart at offset zero
    if (last) begin
      if (!got && phase_q != PH_OPCODE) begin
        r = blank_result();
        r.status = ST_TRUNC;
        got = 1'b1;
      end
      phase_q  = PH_OPCODE;
      byte_pos = 16'h0000;
      halted_q = 1'b0;
    end
    if (got) pending_results = {pending_results, r};
  endfunction

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Compare one output transaction with the oldest expected result
  task automatic check_result();
    mov_result_t e;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual tdata %h tuser %0d",
               $time, m_tdata, m_tuser);
      errors++;
      return;
    end
    e = pending_results.pop_front();
    results_seen++;
    if (e.status == ST_UNKNOWN) unknown_seen++;
    if (e.status == ST_TRUNC) trunc_seen++;
    check_field("status", 16'(e.status), 16'(m_tuser));
    check_field("form", 16'(e.form), 16'(m_tdata[1:0]));
    check_field("wide", 16'(e.wide), 16'(m_tdata[2]));
    check_field("dest_reg", 16'(e.dest_reg), 16'(m_tdata[5:3]));
    check_field("src_reg", 16'(e.src_reg), 16'(m_tdata[8:6]));
    check_field("ea_mode", 16'(e.ea_mode), 16'(m_tdata[11:9]));
    check_field("direct_addr", 16'(e.direct_addr), 16'(m_tdata[12]));
    check_field("displacement", e.displacement, m_tdata[28:13]);
    check_field("immediate", e.immediate, m_tdata[44:29]);
    check_field("position", e.position, m_tdata[60:45]);
    check_field("zero fill", 16'h0000, 16'(m_tdata[63:61]));
  endtask

  // Predict on each input transaction, check on each output transaction
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) decode_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) check_result();
    end
  end

  // Hold off the result side in random bursts
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= (stall_left == 1);
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 9);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  initial begin
    repeat (RUN_LIMIT) @(posedge clk);
    $display("%0t: timeout, %0d results still expected", $time, pending_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Offer one code byte, with an optional gap first, and hold it until taken
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = 0;
    if (idle_en && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 9);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_drained(input int max_cycles);
    int n;
    n = 0;
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0 && n < max_cycles) begin
      @(posedge clk);
      n++;
    end
    repeat (4) @(posedge clk);
  endtask

  // Append one byte to the instruction being built
  function automatic void add_byte(input logic [7:0] b);
    instr_bytes = {instr_bytes, b};
  endfunction

  // Fill instr_bytes with one well-formed MOV of the given kind
  function automatic void build_instr(input kind_t k);
    logic [2:0] reg_f;
    logic [2:0] rm;
    logic       d;
    logic       w;
    reg_f = 3'($urandom);
    rm    = 3'($urandom);
    d     = 1'($urandom);
    w     = 1'($urandom);
    instr_bytes.delete();
    case (k)
      K_IMM8: begin
        add_byte({OP_IMM_REG, 1'b0, reg_f});
        add_byte(8'($urandom));
      end
      K_IMM16: begin
        add_byte({OP_IMM_REG, 1'b1, reg_f});
        add_byte(8'($urandom));
        add_byte(8'($urandom));
      end
      K_REGREG: begin
        add_byte({OP_RM_REG, d, w});
        add_byte({MOD_REGISTER, reg_f, rm});
      end
      K_MEM_NODISP: begin
        if ($urandom_range(0, 2) == 0) rm = RM_DIRECT;
        add_byte({OP_RM_REG, d, w});
        add_byte({MOD_NODISP, reg_f, rm});
        if (rm == RM_DIRECT) begin
          add_byte(8'($urandom));
          add_byte(8'($urandom));
        end
      end
      K_MEM_D8: begin
        add_byte({OP_RM_REG, d, w});
        add_byte({MOD_DISP8, reg_f, rm});
        add_byte(8'($urandom));
      end
      default: begin
        add_byte({OP_RM_REG, d, w});
        add_byte({MOD_DISP16, reg_f, rm});
        add_byte(8'($urandom));
        add_byte(8'($urandom));
      end
    endcase
  endfunction

  // Send the first count bytes of instr_bytes, ending the stream on the last if asked
  task automatic send_instr(input int count, input bit end_stream);
    for (int i = 0; i < count; i++) send_byte(instr_bytes[i], end_stream && i == count - 1);
  endtask

  task automatic test_reset();
    rst <= 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  endtask

  // Every form and width, extreme data, both directions, all displacement sizes
  task automatic test_each_form();
    send_byte(8'hB0, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(8'hBF, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(8'h88, 1'b0); send_byte(8'hC7, 1'b0);
    send_byte(8'h8B, 1'b0); send_byte(8'hF8, 1'b0);
    send_byte(8'h8A, 1'b0); send_byte(8'h07, 1'b0);
    send_byte(8'h89, 1'b0); send_byte(8'h46, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'h8B, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    // direct address, completing exactly on the stream end
    send_byte(8'h88, 1'b0); send_byte(8'h36, 1'b0); send_byte(8'h34, 1'b0);
    send_byte(8'h12, 1'b1);
  endtask

  // Unknown opcode halt, ignored bytes, truncation, end on an opcode byte
  task automatic test_stream_errors();
    send_byte(8'h00, 1'b0);
    send_byte(8'hB0, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hB1, 1'b0); send_byte(8'h7F, 1'b0);
    send_byte(8'h8B, 1'b0); send_byte(8'h80, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hC6, 1'b0);
    send_byte(8'hBF, 1'b1);
  endtask

  // Mostly well-formed instructions with random content, plus broken streams and noise
  task automatic test_random_stream(input int n_bytes, input bit with_idle);
    int         base;
    int         next_toggle;
    int         sel;
    logic [7:0] b;
    base = live_bytes;
    next_toggle = 0;
    while (live_bytes - base < n_bytes) begin
      if (live_bytes - base >= next_toggle) begin
        idle_en = with_idle && $urandom_range(0, 3) != 0;
        next_toggle = live_bytes - base + 100;
      end
      sel = $urandom_range(0, 99);
      if (sel < 80) begin
        build_instr(kind_t'($urandom_range(0, 5)));
        send_instr(instr_bytes.size(), $urandom_range(0, 15) == 0);
      end else if (sel < 88) begin
        build_instr(kind_t'($urandom_range(0, 5)));
        send_instr($urandom_range(1, instr_bytes.size() - 1), 1'b1);
      end else if (sel < 95) begin
        do b = 8'($urandom); while (b[7:4] == OP_IMM_REG || b[7:2] == OP_RM_REG);
        if ($urandom_range(0, 3) == 0) begin
          send_byte(b, 1'b1);
        end else begin
          send_byte(b, 1'b0);
          repeat ($urandom_range(0, 4)) send_byte(8'($urandom), 1'b0);
          send_byte(8'($urandom), 1'b1);
        end
      end else begin
        send_byte(8'($urandom), 1'($urandom_range(0, 3) == 0));
      end
    end
  endtask

  task automatic test_pause_until_drained();
    wait_drained(2000);
  endtask

  initial begin
    test_reset();
    test_each_form();
    test_stream_errors();
    test_random_stream(750, 1'b1);
    test_pause_until_drained();
    test_random_stream(650, 1'b1);
    test_random_stream(150, 1'b0);
    wait_drained(5000);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      errors++;
    end
    $display("Decoded %0d code bytes into %0d results (%0d unknown opcode, %0d truncated),",
             live_bytes, results_seen, unknown_seen, trunc_seen);
    $display("covering all MOV forms, halts, cut-off streams and output stalls; %0d errors",
             errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
